/* design/mhia_pkg.sv */
// Shared constants and types for the minimum-first id allocator.
`timescale 1ns / 1ps

package mhia_pkg;

    localparam int ID_W       = 32;
    localparam int COUNT_W    = 11;
    localparam int HEAP_DEPTH = 1024;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int HEAP_CW    = $clog2(HEAP_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_WATER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRESH = 2'd2;

    // Command into the heap engine: push value, or pop the minimum if below value.
    typedef struct packed {
        logic            start;
        logic            pop;
        logic [ID_W-1:0] value;
    } t_heap_cmd;

    // Engine response; count is the value the count takes after this cycle,
    // held is the count as it stands now.
    typedef struct packed {
        logic               done;
        logic               hit;
        logic [ID_W-1:0]    min_id;
        logic [HEAP_CW-1:0] count;
        logic [HEAP_CW-1:0] held;
    } t_heap_rsp;

endpackage

/* design/mhia_heap.sv */
// Binary min-heap engine: heap memory, element count and sift-up/sift-down sequencer.
`timescale 1ns / 1ps

module mhia_heap
    import mhia_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_heap_cmd i_cmd,
    output t_heap_rsp o_rsp
);

    localparam int CHILD_W = HEAP_AW + 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UP    = 5'b00010,
        S_ROOT  = 5'b00100,
        S_DOWN  = 5'b01000,
        S_WLAST = 5'b10000
    } t_heap_state;

    t_heap_state r_state, n_state;
    logic [HEAP_CW-1:0] r_count, n_count;
    logic [HEAP_AW-1:0] r_pos, n_pos;
    logic [ID_W-1:0]    r_val, n_val;
    logic [ID_W-1:0]    r_limit, n_limit;
    logic [ID_W-1:0]    r_min, n_min;
    logic               r_hit, n_hit;

    logic [ID_W-1:0]    mem [HEAP_DEPTH];
    logic [ID_W-1:0]    r_rd_a, r_rd_b;
    logic [HEAP_AW-1:0] rd_addr_a, rd_addr_b;
    logic               wr_en;
    logic [HEAP_AW-1:0] wr_addr;
    logic [ID_W-1:0]    wr_data;

    logic [HEAP_AW-1:0] parent;
    logic [CHILD_W-1:0] child, right, nchild;
    logic               take_right;
    logic [ID_W-1:0]    cval;
    logic [HEAP_AW-1:0] cidx;
    logic               done;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    always_comb begin
        parent     = (r_pos - 1'b1) >> 1;
        child      = {1'b0, r_pos, 1'b1};
        right      = child + 1'b1;
        take_right = (right < CHILD_W'(r_count)) && (r_rd_b < r_rd_a);
        cval       = take_right ? r_rd_b : r_rd_a;
        cidx       = take_right ? right[HEAP_AW-1:0] : child[HEAP_AW-1:0];
        nchild     = {1'b0, cidx, 1'b1};
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_limit   = r_limit;
        n_min     = r_min;
        n_hit     = r_hit;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_val;
        done      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_hit = 1'b0;
                end
                if (i_cmd.start && !i_cmd.pop) begin
                    n_count = r_count + 1'b1;
                    n_val   = i_cmd.value;
                    if (r_count == '0) begin
                        // empty heap: write the root next cycle
                        n_pos   = '0;
                        n_state = S_WLAST;
                    end else begin
                        n_pos     = r_count[HEAP_AW-1:0];
                        rd_addr_a = HEAP_AW'((r_count - 1'b1) >> 1);
                        n_state   = S_UP;
                    end
                end else if (i_cmd.start) begin
                    // read root and last element together
                    n_limit   = i_cmd.value;
                    rd_addr_a = '0;
                    rd_addr_b = HEAP_AW'(r_count - 1'b1);
                    n_state   = S_ROOT;
                end
            end
            S_UP: begin
                wr_en = 1'b1;
                if (r_rd_a <= r_val) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // move parent down one level and climb
                    wr_data = r_rd_a;
                    n_pos   = parent;
                    if (parent == '0) begin
                        n_state = S_WLAST;
                    end else begin
                        rd_addr_a = (parent - 1'b1) >> 1;
                    end
                end
            end
            S_ROOT: begin
                if (r_rd_a < r_limit) begin
                    n_hit   = 1'b1;
                    n_min   = r_rd_a;
                    n_count = r_count - 1'b1;
                    n_val   = r_rd_b;
                    n_pos   = '0;
                    if (r_count == HEAP_CW'(1)) begin
                        done    = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_count == HEAP_CW'(2)) begin
                        n_state = S_WLAST;
                    end else begin
                        rd_addr_a = HEAP_AW'(1);
                        rd_addr_b = HEAP_AW'(2);
                        n_state   = S_DOWN;
                    end
                end else begin
                    n_hit   = 1'b0;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DOWN: begin
                wr_en = 1'b1;
                if (r_val <= cval) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // pull the smaller child up and descend
                    wr_data = cval;
                    n_pos   = cidx;
                    if (nchild >= CHILD_W'(r_count)) begin
                        n_state = S_WLAST;
                    end else begin
                        rd_addr_a = nchild[HEAP_AW-1:0];
                        rd_addr_b = HEAP_AW'(nchild + 1'b1);
                    end
                end
            end
            S_WLAST: begin
                wr_en   = 1'b1;
                done    = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hit   <= n_hit;
        end
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_limit <= n_limit;
        r_min   <= n_min;
    end

    always_comb begin
        o_rsp.done   = done;
        o_rsp.hit    = n_hit;
        o_rsp.min_id = (r_state == S_ROOT) ? r_rd_a : r_min;
        o_rsp.count  = n_count;
        o_rsp.held   = r_count;
    end

endmodule

/* design/min_heap_id_allocator.sv */
// Top level of the minimum-first id allocator: handshakes, registers, fresh counter.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Beat
// -------   ---------  -----------------------  --------------------------------------
// in        sink       i_in_valid / o_in_stall  op, free_id, limit, store_only
// out       source     o_out_valid / i_out_stall given_id, granted, from_store,
//                                               below_low_water, rejected, store_count
// cfg       sink       i_cfg_valid / o_cfg_ready register index, write data
//
// One item at a time. A rejected free or an allocate against an empty store finishes
// in the accept cycle. A stored free walks up the heap, one level per cycle, ending
// with one write. A pop reads root and last element, then walks down one level per
// cycle using both read ports. The finished result then sits in a holding register
// that blocks the input; a stalled out channel with a full output register keeps the
// result in the holding register and the input stalled. Reset clears the count and
// flags and resets the configuration and fresh counter registers; heap memory is not
// cleared and needs no clearing pass.

module min_heap_id_allocator
    import mhia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [ID_W-1:0]      i_free_id,
    input  logic [ID_W-1:0]      i_limit,
    input  logic                 i_store_only,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ID_W-1:0]      o_given_id,
    output logic                 o_granted,
    output logic                 o_from_store,
    output logic                 o_below_low_water,
    output logic                 o_rejected,
    output logic [COUNT_W-1:0]   o_store_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ID_W-1:0]      i_cfg_data
);

    // configuration and fresh counter
    logic [ID_W-1:0]    r_max_id;
    logic [COUNT_W-1:0] r_low_water;
    logic [ID_W-1:0]    r_fresh;

    // item in flight and result holding register
    logic               r_busy;
    logic               r_res_valid;
    logic [ID_W-1:0]    r_res_id;
    logic               r_res_granted;
    logic               r_res_store;
    logic               r_res_low;
    logic               r_res_rej;
    logic [COUNT_W-1:0] r_res_count;

    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_granted;
    logic               r_out_store;
    logic               r_out_low;
    logic               r_out_rej;
    logic [COUNT_W-1:0] r_out_count;

    t_heap_cmd heap_cmd;
    t_heap_rsp heap_rsp;

    logic in_fire;
    logic cfg_fire;
    logic res_move;
    logic is_full;
    logic reject;
    logic is_empty;
    logic fresh_ok;

    mhia_heap u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (heap_cmd),
        .o_rsp   (heap_rsp)
    );

    assign o_in_stall  = r_busy || r_res_valid;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign res_move    = r_res_valid && (!r_out_valid || !i_out_stall);

    // Decide at accept whether the heap is needed, from the count as it stands.
    assign is_full  = heap_rsp.held >= HEAP_CW'(HEAP_DEPTH);
    assign reject   = (i_free_id > r_max_id) || is_full;
    assign is_empty = heap_rsp.held == '0;
    assign fresh_ok = !i_store_only && (r_fresh < i_limit);

    always_comb begin
        heap_cmd.start = 1'b0;
        heap_cmd.pop   = i_op;
        heap_cmd.value = i_op ? i_limit : i_free_id;
        if (in_fire) begin
            heap_cmd.start = i_op ? !is_empty : !reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id    <= '1;
            r_low_water <= '0;
            r_fresh     <= ID_W'(1);
            r_busy      <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_MAX_ID:      r_max_id    <= i_cfg_data;
                    CFG_LOW_WATER:   r_low_water <= i_cfg_data[COUNT_W-1:0];
                    CFG_FIRST_FRESH: r_fresh     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_fire) begin
                if (heap_cmd.start) begin
                    r_busy <= 1'b1;
                end else begin
                    // finished at accept: rejected free or fresh path
                    r_res_valid   <= 1'b1;
                    r_res_id      <= (i_op && fresh_ok) ? r_fresh : '0;
                    r_res_granted <= i_op && fresh_ok && (r_fresh != '0);
                    r_res_store   <= 1'b0;
                    r_res_low     <= 1'b0;
                    r_res_rej     <= !i_op;
                    r_res_count   <= COUNT_W'(heap_rsp.held);
                    if (i_op && fresh_ok) begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                end
            end else if (r_busy && heap_rsp.done) begin
                r_busy        <= 1'b0;
                r_res_valid   <= 1'b1;
                r_res_rej     <= 1'b0;
                r_res_count   <= COUNT_W'(heap_rsp.count);
                // hit is only ever set by a pop that took the minimum
                if (heap_rsp.hit) begin
                    r_res_id      <= heap_rsp.min_id;
                    r_res_granted <= heap_rsp.min_id != '0;
                    r_res_store   <= 1'b1;
                    r_res_low     <= ID_W'(heap_rsp.count) < ID_W'(r_low_water);
                end else begin
                    r_res_id      <= '0;
                    r_res_granted <= 1'b0;
                    r_res_store   <= 1'b0;
                    r_res_low     <= 1'b0;
                end
            end else if (res_move) begin
                r_res_valid <= 1'b0;
            end

            if (res_move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (res_move) begin
            r_out_id      <= r_res_id;
            r_out_granted <= r_res_granted;
            r_out_store   <= r_res_store;
            r_out_low     <= r_res_low;
            r_out_rej     <= r_res_rej;
            r_out_count   <= r_res_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_given_id        = r_out_id;
    assign o_granted         = r_out_granted;
    assign o_from_store      = r_out_store;
    assign o_below_low_water = r_out_low;
    assign o_rejected        = r_out_rej;
    assign o_store_count     = r_out_count;

endmodule
